/* rtl/core/minmax_normalize_classify_unit_macros.svh */
// Assertion macros used by the checker of the min-max classify unit.
`ifndef MINMAX_NORMALIZE_CLASSIFY_UNIT_MACROS_SVH
`define MINMAX_NORMALIZE_CLASSIFY_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MNC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mnc_pkg.sv */
// Shared constants, types and state codes of the min-max classify unit.
package mnc_pkg;

  localparam int unsigned DEPTH_DEF      = 4096;
  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned CNT_W_DEF      = $clog2(DEPTH_DEF + 1);

  // Mean score is percent in Q8, so at most 100 * 256.
  localparam int unsigned MEAN_W   = 15;
  localparam int unsigned MEAN_MAX = 25600;

  // 25600 = 2^14 + 2^13 + 2^10, applied as three shifted terms.
  localparam int unsigned SCALE_SH_HI  = 14;
  localparam int unsigned SCALE_SH_MID = 13;
  localparam int unsigned SCALE_SH_LO  = 10;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_SCALE,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic start;
    logic ok;
  } rd_req_t;

endpackage

/* rtl/core/minmax_normalize_classify_unit.sv */
// Top level of the min-max normalisation and mean-threshold classify unit.
// Load requests (mode 0) are taken one per clock while in_stall is low: each writes its
// sample to the on-chip sample memory and updates the running count, minimum, maximum
// and sum in the same cycle. The load that carries last closes the vector; input then
// stalls while two multiplies and a subtract run, and also while the bit-serial mean
// divider runs when the samples differ. A read request (mode 1) goes through the
// memory's registered read port, a multiply stage and the compare into the output
// register; no new request is taken until the read has left the multiply stage and
// the compare, which takes longer while a result is held by output stall.
// The sample memory needs no clearing after reset.
module minmax_normalize_classify_unit #(
  parameter int unsigned DEPTH      = mnc_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = mnc_pkg::VALUE_BITS_DEF,
  localparam int unsigned IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         mode,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         last,
  input  logic [IDX_W-1:0]             index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         index_ok,
  output logic                         class_bit,
  output logic signed [VALUE_BITS-1:0] min_value,
  output logic signed [VALUE_BITS-1:0] max_value,
  output logic [mnc_pkg::MEAN_W-1:0]   mean_q8,
  output logic [CNT_W-1:0]             sample_count
);

  import mnc_pkg::*;

  localparam int unsigned SUM_W  = VALUE_BITS + CNT_W;
  localparam int unsigned NMIN_W = SUM_W + 1;
  localparam int unsigned SPAN_W = VALUE_BITS + 1;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
  localparam logic signed [VALUE_BITS-1:0] MIN_RESET = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] MAX_RESET = {1'b1, {(VALUE_BITS-1){1'b0}}};

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;
  logic signed [VALUE_BITS-1:0]  run_min;
  logic signed [VALUE_BITS-1:0]  run_min_next;
  logic signed [VALUE_BITS-1:0]  run_max;
  logic signed [VALUE_BITS-1:0]  run_max_next;
  logic signed [SUM_W-1:0]       run_sum;
  logic signed [SUM_W-1:0]       run_sum_next;
  logic [MEAN_W-1:0]             mean;
  logic [MEAN_W-1:0]             mean_next;
  logic                          complete;
  logic                          complete_next;

  logic signed [NMIN_W-1:0]      nmin;
  logic [SUM_W-1:0]              den;
  logic [SUM_W-1:0]              rhs;

  logic                          accept;
  logic                          load_acc;
  logic                          read_acc;
  logic                          read_ok;
  logic                          rd_busy;
  logic                          div_start;
  logic                          div_done;
  logic [MEAN_W-1:0]             div_quo;
  logic                          flat;
  rd_req_t                       rd_req;
  logic signed [VALUE_BITS-1:0]  rd_data;

  logic [CNT_W-1:0]              base_cnt;
  logic signed [VALUE_BITS-1:0]  base_min;
  logic signed [VALUE_BITS-1:0]  base_max;
  logic signed [SUM_W-1:0]       base_sum;
  logic                          has_room;
  logic signed [SPAN_W-1:0]      span;
  logic signed [NMIN_W-1:0]      nmin_prod;
  logic signed [NMIN_W-1:0]      num_full;
  logic [SUM_W-1:0]              den_prod;

  assign accept   = in_valid && !in_stall;
  assign load_acc = accept && (mode == MODE_LOAD);
  assign read_acc = accept && (mode == MODE_READ);
  assign read_ok  = complete && (CNT_W'(index) < count);

  // A load after a closed vector starts from the cleared statistics.
  assign base_cnt = complete ? '0 : count;
  assign base_min = complete ? MIN_RESET : run_min;
  assign base_max = complete ? MAX_RESET : run_max;
  assign base_sum = complete ? '0 : run_sum;
  assign has_room = (base_cnt != FULL_COUNT);

  assign flat      = (count == '0) || (run_max <= run_min);
  assign span      = SPAN_W'(run_max) - SPAN_W'(run_min);
  assign nmin_prod = NMIN_W'($signed({1'b0, count})) * NMIN_W'(run_min);
  assign den_prod  = SUM_W'(count) * SUM_W'(span[VALUE_BITS-1:0]);
  assign num_full  = NMIN_W'(run_sum) - nmin;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (load_acc && last) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_SUB;
      end
      ST_SUB: begin
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        state_next = flat ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE) || rd_busy;
    div_start = (state == ST_SCALE) && !flat;
  end

  always_comb begin
    count_next    = count;
    run_min_next  = run_min;
    run_max_next  = run_max;
    run_sum_next  = run_sum;
    mean_next     = mean;
    complete_next = complete;
    if (load_acc) begin
      count_next    = has_room ? base_cnt + 1'b1 : base_cnt;
      run_min_next  = (has_room && (value < base_min)) ? value : base_min;
      run_max_next  = (has_room && (value > base_max)) ? value : base_max;
      run_sum_next  = has_room ? base_sum + SUM_W'(value) : base_sum;
      mean_next     = '0;
      complete_next = 1'b0;
    end else if ((state == ST_SCALE) && flat) begin
      complete_next = 1'b1;
    end else if ((state == ST_DIV) && div_done) begin
      mean_next     = div_quo;
      complete_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      run_min  <= MIN_RESET;
      run_max  <= MAX_RESET;
      run_sum  <= '0;
      mean     <= '0;
      complete <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      run_min  <= run_min_next;
      run_max  <= run_max_next;
      run_sum  <= run_sum_next;
      mean     <= mean_next;
      complete <= complete_next;
    end
  end

  // rhs = sum - n*min is both the divider's numerator and the threshold
  // that every read of this vector is compared against.
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      nmin <= nmin_prod;
      den  <= den_prod;
    end
    if (state == ST_SUB) begin
      rhs <= num_full[SUM_W-1:0];
    end
  end

  assign rd_req.start = read_acc;
  assign rd_req.ok    = read_ok;

  mnc_store #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_acc && has_room),
    .wr_addr (base_cnt[IDX_W-1:0]),
    .wr_data (value),
    .rd_en   (read_acc && read_ok),
    .rd_addr (index),
    .rd_data (rd_data)
  );

  mnc_divider #(
    .NUM_W (SUM_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (rhs),
    .den      (den),
    .done     (div_done),
    .quotient (div_quo)
  );

  mnc_classify #(
    .VALUE_BITS (VALUE_BITS),
    .CNT_W      (CNT_W)
  ) u_classify (
    .clk          (clk),
    .rst          (rst),
    .req          (rd_req),
    .busy         (rd_busy),
    .rd_data      (rd_data),
    .run_min      (run_min),
    .run_max      (run_max),
    .count        (count),
    .mean         (mean),
    .rhs          (rhs),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .index_ok     (index_ok),
    .class_bit    (class_bit),
    .min_value    (min_value),
    .max_value    (max_value),
    .mean_q8      (mean_q8),
    .sample_count (sample_count)
  );

endmodule

/* rtl/core/mnc_store.sv */
// Sample memory: one write port, one registered read port.
module mnc_store #(
  parameter int unsigned DEPTH      = mnc_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = mnc_pkg::VALUE_BITS_DEF,
  parameter int unsigned IDX_W      = 12
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_addr,
  input  logic signed [VALUE_BITS-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [IDX_W-1:0]             rd_addr,
  output logic signed [VALUE_BITS-1:0] rd_data
);

  logic signed [VALUE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/mnc_divider.sv */
// Restoring divider that forms the Q8 percent mean, one quotient bit a cycle.
module mnc_divider #(
  parameter int unsigned NUM_W = mnc_pkg::VALUE_BITS_DEF + mnc_pkg::CNT_W_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  input  logic [NUM_W-1:0]          den,
  output logic                      done,
  output logic [mnc_pkg::MEAN_W-1:0] quotient
);

  import mnc_pkg::*;

  localparam int unsigned DIV_W  = NUM_W + MEAN_W;
  localparam int unsigned STEP_W = $clog2(MEAN_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MEAN_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsr;
  logic [DIV_W-1:0]  dividend;
  logic              ge;

  assign dividend = (DIV_W'(num) << SCALE_SH_HI) + (DIV_W'(num) << SCALE_SH_MID)
                  + (DIV_W'(num) << SCALE_SH_LO);
  assign ge = (rem >= dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient is known to stay below 2^MEAN_W, so the divisor starts
  // aligned to the top quotient bit and slides right once per step.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsr      <= {1'b0, den, {(MEAN_W-1){1'b0}}};
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsr;
      end
      dsr      <= dsr >> 1;
      quotient <= {quotient[MEAN_W-2:0], ge};
    end
  end

endmodule

/* rtl/core/mnc_classify.sv */
// Read pipeline: scales the fetched sample, compares it with the mean and holds the result.
module mnc_classify #(
  parameter int unsigned VALUE_BITS = mnc_pkg::VALUE_BITS_DEF,
  parameter int unsigned CNT_W      = mnc_pkg::CNT_W_DEF,
  localparam int unsigned SUM_W     = VALUE_BITS + CNT_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mnc_pkg::rd_req_t              req,
  output logic                          busy,
  input  logic signed [VALUE_BITS-1:0]  rd_data,
  input  logic signed [VALUE_BITS-1:0]  run_min,
  input  logic signed [VALUE_BITS-1:0]  run_max,
  input  logic [CNT_W-1:0]              count,
  input  logic [mnc_pkg::MEAN_W-1:0]    mean,
  input  logic [SUM_W-1:0]              rhs,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          index_ok,
  output logic                          class_bit,
  output logic signed [VALUE_BITS-1:0]  min_value,
  output logic signed [VALUE_BITS-1:0]  max_value,
  output logic [mnc_pkg::MEAN_W-1:0]    mean_q8,
  output logic [CNT_W-1:0]              sample_count
);

  import mnc_pkg::*;

  localparam int unsigned DIFF_W = VALUE_BITS + 1;

  logic                     p1_valid;
  logic                     p1_ok;
  logic                     p2_valid;
  logic                     p2_ok;
  logic                     move;
  logic signed [DIFF_W-1:0] diff;
  logic [SUM_W-1:0]         lhs_prod;
  logic [SUM_W-1:0]         lhs;

  // A stored sample never lies below the minimum of its vector.
  assign diff     = DIFF_W'(rd_data) - DIFF_W'(run_min);
  assign lhs_prod = SUM_W'(count) * SUM_W'(diff[VALUE_BITS-1:0]);
  assign move     = p2_valid && (!out_valid || !out_stall);
  assign busy     = p1_valid || p2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1_valid <= req.start;
      if (p1_valid) begin
        p2_valid <= 1'b1;
      end else if (move) begin
        p2_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      p1_ok <= req.ok;
    end
    if (p1_valid) begin
      p2_ok <= p1_ok;
      lhs   <= lhs_prod;
    end
    if (move) begin
      index_ok     <= p2_ok;
      class_bit    <= p2_ok && (lhs >= rhs);
      min_value    <= run_min;
      max_value    <= run_max;
      mean_q8      <= mean;
      sample_count <= count;
    end
  end

endmodule

/* rtl/core/mnc_checker.sv */
// Port-level checker for the min-max classify unit and its bind statement.
`include "minmax_normalize_classify_unit_macros.svh"

module mnc_checker #(
  parameter int unsigned DEPTH      = mnc_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_BITS = mnc_pkg::VALUE_BITS_DEF,
  localparam int unsigned IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         mode,
  input logic signed [VALUE_BITS-1:0] value,
  input logic                         last,
  input logic [IDX_W-1:0]             index,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         index_ok,
  input logic                         class_bit,
  input logic signed [VALUE_BITS-1:0] min_value,
  input logic signed [VALUE_BITS-1:0] max_value,
  input logic [mnc_pkg::MEAN_W-1:0]   mean_q8,
  input logic [CNT_W-1:0]             sample_count
);

  import mnc_pkg::*;

  `MNC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(index_ok) && $stable(class_bit) && $stable(mean_q8),
    "stalled result changed")
  `MNC_ASSERT_NOW(a_class_needs_ok, out_valid && !index_ok, !class_bit,
    "class set on a rejected read")
  `MNC_ASSERT_NOW(a_ok_vector_sane, out_valid && index_ok,
    (min_value <= max_value) && (sample_count != '0),
    "accepted read on an empty or inverted vector")
  `MNC_ASSERT_NOW(a_mean_range, out_valid, mean_q8 <= MEAN_MAX,
    "mean above one hundred percent")
  `MNC_ASSERT_NOW(a_flat_vector, out_valid && index_ok && (min_value == max_value),
    class_bit && (mean_q8 == '0), "flat vector misclassified")

endmodule

bind minmax_normalize_classify_unit mnc_checker #(
  .DEPTH      (DEPTH),
  .VALUE_BITS (VALUE_BITS)
) u_mnc_checker (.*);

/* verif/minmax_normalize_classify_unit_tb.sv */
// Self-checking testbench of the min-max normalise and mean-threshold classify unit.
module minmax_normalize_classify_unit_tb;
  import mnc_pkg::*;

  localparam int DEPTH         = DEPTH_DEF;
  localparam int VBITS         = VALUE_BITS_DEF;
  localparam int IDX_W         = $clog2(DEPTH);
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS  = 1490;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_LIMIT  = 10;

  localparam logic signed [VBITS-1:0] VAL_MAX = {1'b0, {(VBITS-1){1'b1}}};
  localparam logic signed [VBITS-1:0] VAL_MIN = {1'b1, {(VBITS-1){1'b0}}};

  typedef enum int {
    SAMPLES_ANY,
    SAMPLES_NARROW,
    SAMPLES_CONSTANT,
    SAMPLES_EXTREMES,
    SAMPLES_TWO_LEVEL
  } sample_style_t;

  typedef struct {
    logic                    ok;
    logic                    cls;
    logic signed [VBITS-1:0] lo;
    logic signed [VBITS-1:0] hi;
    logic [MEAN_W-1:0]       mean;
    logic [CNT_W-1:0]        cnt;
  } class_result_t;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic                    mode      = MODE_LOAD;
  logic signed [VBITS-1:0] value     = '0;
  logic                    last      = 1'b0;
  logic [IDX_W-1:0]        index     = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    index_ok;
  logic                    class_bit;
  logic signed [VBITS-1:0] min_value;
  logic signed [VBITS-1:0] max_value;
  logic [MEAN_W-1:0]       mean_q8;
  logic [CNT_W-1:0]        sample_count;

  // Predictor state: the vector as the unit should hold it.
  logic signed [VBITS-1:0] sample_mem [DEPTH];
  int                      vec_count;
  longint                  vec_min;
  longint                  vec_max;
  longint                  vec_sum;
  int                      vec_mean;
  bit                      vec_closed;

  class_result_t expected_reads[$];
  int            failures        = 0;
  int            items_sent      = 0;
  bit            sender_idles    = 1'b1;
  bit            receiver_stalls = 1'b1;
  int            burst_left      = 0;
  int            hold_request    = 0;
  int            hold_left       = 0;
  logic [15:0]   stall_pattern   = 16'h0000;
  logic [3:0]    stall_phase     = 4'd0;

  always #6 clk = ~clk;

  minmax_normalize_classify_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .value        (value),
    .last         (last),
    .index        (index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .index_ok     (index_ok),
    .class_bit    (class_bit),
    .min_value    (min_value),
    .max_value    (max_value),
    .mean_q8      (mean_q8),
    .sample_count (sample_count)
  );

  function automatic void clear_vector_state();
    vec_count  = 0;
    vec_min    = VAL_MAX;
    vec_max    = VAL_MIN;
    vec_sum    = 0;
    vec_mean   = 0;
    vec_closed = 1'b0;
  endfunction

  function automatic void apply_load(input logic signed [VBITS-1:0] v, input logic l);
    longint sv;
    sv = v;
    // A load after a closed vector starts a fresh one.
    if (vec_closed) clear_vector_state();
    if (vec_count < DEPTH) begin
      sample_mem[vec_count] = v;
      vec_count++;
      if (sv < vec_min) vec_min = sv;
      if (sv > vec_max) vec_max = sv;
      vec_sum += sv;
    end
    if (l) begin
      vec_closed = 1'b1;
      vec_mean   = 0;
      if (vec_count != 0 && vec_max > vec_min)
        vec_mean = int'(((vec_sum - vec_count * vec_min) * MEAN_MAX) /
                        (vec_count * (vec_max - vec_min)));
    end
  endfunction

  function automatic class_result_t classify_read(input logic [IDX_W-1:0] idx);
    class_result_t r;
    longint        sv;
    r.ok  = 1'b0;
    r.cls = 1'b0;
    if (vec_closed && int'(idx) < vec_count) begin
      sv    = sample_mem[idx];
      r.ok  = 1'b1;
      // Exact form of "normalised value at or above the mean".
      r.cls = ((sv - vec_min) * vec_count >= vec_sum - vec_count * vec_min);
    end
    r.lo   = vec_min[VBITS-1:0];
    r.hi   = vec_max[VBITS-1:0];
    r.mean = vec_mean[MEAN_W-1:0];
    r.cnt  = vec_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic signed [VBITS-1:0] pick_sample(input sample_style_t style,
                                                          input logic signed [VBITS-1:0] base);
    case (style)
      SAMPLES_NARROW:    return base + VBITS'($urandom_range(0, 16)) - VBITS'(8);
      SAMPLES_CONSTANT:  return base;
      SAMPLES_EXTREMES:  return ($urandom_range(0, 3) == 0) ? VBITS'($urandom) :
                                ($urandom_range(0, 1) == 0) ? VAL_MIN : VAL_MAX;
      SAMPLES_TWO_LEVEL: return base + VBITS'($urandom_range(0, 1));
      default:           return VBITS'($urandom);
    endcase
  endfunction

  // Offers one request, waits for it to be taken and updates the prediction.
  task automatic send_request(input logic m, input logic signed [VBITS-1:0] v, input logic l,
                              input logic [IDX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_idles ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    mode     <= m;
    value    <= v;
    last     <= l;
    index    <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (m == MODE_LOAD) apply_load(v, l);
    else expected_reads.push_back(classify_read(idx));
  endtask

  task automatic send_load(input logic signed [VBITS-1:0] v, input logic l);
    send_request(MODE_LOAD, v, l, IDX_W'($urandom));
  endtask

  task automatic send_read(input logic [IDX_W-1:0] idx);
    send_request(MODE_READ, VBITS'($urandom), 1'($urandom), idx);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    // The mean divider may still be busy after a closing load.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reads_before_any_load();
    send_read('0);
    send_read('1);
  endtask

  task automatic test_extreme_samples();
    int i;
    send_load(VAL_MIN, 1'b0);
    send_load(VAL_MAX, 1'b0);
    send_read(IDX_W'(1));
    send_load('0, 1'b0);
    send_load('1, 1'b0);
    send_load(VBITS'(1), 1'b1);
    for (i = 0; i <= 5; i++) send_read(IDX_W'(i));
    send_read('1);
  endtask

  task automatic test_equal_extremes();
    int i;
    for (i = 0; i < 3; i++) send_load(VBITS'(12345), i == 2);
    for (i = 0; i < 4; i++) send_read(IDX_W'(i));
    send_load(VAL_MIN, 1'b1);
    send_read('0);
    // Another single-sample vector, closed by its only load.
    send_load(VAL_MAX, 1'b1);
    send_read('0);
    send_read(IDX_W'(1));
  endtask

  task automatic test_output_hold_off();
    int i;
    for (i = 0; i < 8; i++) send_load(VBITS'($urandom), i == 7);
    hold_request = HOLD_CYCLES;
    for (i = 0; i < 24; i++) send_read(IDX_W'($urandom_range(0, 8)));
    drain_results();
  endtask

  task automatic test_random_vectors();
    int                      first_item;
    int                      len;
    int                      reads;
    int                      pick;
    int                      j;
    sample_style_t           style;
    logic signed [VBITS-1:0] base;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        sender_idles    = ($urandom_range(0, 3) != 0);
        receiver_stalls = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 19);
      len  = (pick < 14) ? $urandom_range(1, 12) :
             (pick < 19) ? $urandom_range(13, 60) : $urandom_range(61, 300);
      style = sample_style_t'($urandom_range(0, 4));
      base  = VBITS'($urandom);
      for (j = 0; j < len; j++) begin
        // Occasional read while the vector is still open.
        if ($urandom_range(0, 15) == 0) send_read(IDX_W'($urandom));
        send_load(pick_sample(style, base), j == len - 1);
      end
      reads = $urandom_range(0, 12);
      for (j = 0; j < reads; j++) begin
        if ($urandom_range(0, 7) == 0) send_read(IDX_W'($urandom));
        else send_read(IDX_W'($urandom_range(0, vec_count - 1)));
      end
      if ($urandom_range(0, 9) == 0) drain_results();
    end
  endtask

  // Receiver: a long hold-off on request, otherwise a rotating stall pattern or no stall.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (receiver_stalls) begin
      out_stall <= stall_pattern[stall_phase];
      stall_phase = stall_phase + 4'd1;
      if (stall_phase == 4'd0)
        stall_pattern = ($urandom_range(0, 1) == 0) ? 16'($urandom & $urandom) : 16'($urandom);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    class_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_reads.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result: ok=%0b class=%0b min=%0d max=%0d mean=%0d count=%0d",
                   index_ok, class_bit, min_value, max_value, mean_q8, sample_count);
      end else begin
        want = expected_reads.pop_front();
        if (index_ok !== want.ok || class_bit !== want.cls || min_value !== want.lo ||
            max_value !== want.hi || mean_q8 !== want.mean || sample_count !== want.cnt) begin
          failures++;
          if (failures <= REPORT_LIMIT) begin
            $display("mismatch: expected ok=%0b class=%0b min=%0d max=%0d mean=%0d count=%0d",
                     want.ok, want.cls, want.lo, want.hi, want.mean, want.cnt);
            $display("          actual   ok=%0b class=%0b min=%0d max=%0d mean=%0d count=%0d",
                     index_ok, class_bit, min_value, max_value, mean_q8, sample_count);
          end
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    clear_vector_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reads_before_any_load();
    test_extreme_samples();
    test_equal_extremes();
    test_output_hold_off();
    test_random_vectors();
    drain_results();
    if (failures == 0 && expected_reads.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
